// ===== rtl/core/serial_to_can_motor_gateway_macros.svh =====
// assertion helpers shared by the gateway modules
`ifndef SERIAL_TO_CAN_MOTOR_GATEWAY_MACROS_SVH
`define SERIAL_TO_CAN_MOTOR_GATEWAY_MACROS_SVH

// same-cycle implication, checked outside reset
`define S2CMG_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gateway assertion failed");

// next-cycle implication, checked outside reset
`define S2CMG_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gateway assertion failed");

`endif

// ===== rtl/core/s2cmg_pkg.sv =====
`timescale 1ns / 1ps

package s2cmg_pkg;

  // motor count and derived widths
  localparam int MOTORS  = 8;
  localparam int MOTOR_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // command frame
  localparam int FRAME_LEN = 19;
  localparam int POS_W     = 5;
  localparam int SUM_LAST  = 16;

  // reply store and serial reply
  localparam int STORE_LEN = 32;
  localparam int STORE_AW  = 5;
  localparam int SER_LEN   = STORE_LEN + 3;
  localparam int SER_W     = 6;

  localparam int ID_W = 11;
  localparam logic [ID_W-1:0] BASE_RESET = 11'h141;

  // byte codes
  localparam logic [7:0] HDR_BYTE   = 8'h5A;
  localparam logic [7:0] TRL_BYTE   = 8'hA5;
  localparam logic [7:0] QUERY_MARK = 8'hFF;
  localparam logic [7:0] NO_CHECK   = 8'h00;
  localparam logic [7:0] CMD_TORQUE = 8'hA1;
  localparam logic [7:0] CMD_QUERY  = 8'h9C;
  localparam logic [7:0] CMD_ON     = 8'h81;
  localparam logic [7:0] CMD_OFF    = 8'h88;

  // input word kinds
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_REPLY = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  typedef struct packed {
    logic       byte_we;
    logic       reply_we;
    logic       cmd_load;
    logic [7:0] cmd_code;
    logic       emit_can;
    logic       emit_ser;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic frame_ok;
    logic query;
    logic k_last;
    logic j_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/s2cmg_ctrl.sv =====
`timescale 1ns / 1ps
`include "serial_to_can_motor_gateway_macros.svh"

module s2cmg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic [1:0]           in_func,
  output logic                 in_tready,
  input  s2cmg_pkg::dp_stat_t  stat,
  output s2cmg_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_BCAST = 2'd2;
  localparam logic [1:0] S_REPLY = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       reply_r, reply_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    reply_nxt    = reply_r;
    cmd          = '0;
    cmd.cmd_code = s2cmg_pkg::CMD_ON;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            s2cmg_pkg::FUNC_BYTE: begin
              cmd.byte_we = 1'b1;
              if (stat.frame_done) begin
                state_nxt = S_CHECK;
              end
            end
            s2cmg_pkg::FUNC_REPLY: begin
              cmd.reply_we = 1'b1;
            end
            s2cmg_pkg::FUNC_START: begin
              cmd.cmd_load = 1'b1;
              cmd.cmd_code = s2cmg_pkg::CMD_ON;
              reply_nxt    = 1'b0;
              state_nxt    = S_BCAST;
            end
            default: begin
              cmd.cmd_load = 1'b1;
              cmd.cmd_code = s2cmg_pkg::CMD_OFF;
              reply_nxt    = 1'b0;
              state_nxt    = S_BCAST;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (stat.frame_ok) begin
          cmd.cmd_load = 1'b1;
          cmd.cmd_code = stat.query ? s2cmg_pkg::CMD_QUERY : s2cmg_pkg::CMD_TORQUE;
          reply_nxt    = 1'b1;
          state_nxt    = S_BCAST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BCAST: begin
        if (stat.out_free) begin
          cmd.emit_can = 1'b1;
          cmd.out_last = stat.k_last && !reply_r;
          if (stat.k_last) begin
            state_nxt = reply_r ? S_REPLY : S_IDLE;
          end
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.emit_ser = 1'b1;
          cmd.out_last = stat.j_last;
          if (stat.j_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  `S2CMG_ASSERT_IMPL(a_emit_free, cmd.emit_can || cmd.emit_ser, stat.out_free)
  `S2CMG_ASSERT_IMPL(a_emit_one, cmd.emit_can, !cmd.emit_ser)
  `S2CMG_ASSERT_NEXT(a_check_once, state_r == S_CHECK, state_r != S_CHECK)
  `S2CMG_ASSERT_IMPL(a_no_emit_idle, in_tready, !cmd.emit_can && !cmd.emit_ser)

endmodule

// ===== rtl/core/s2cmg_dp.sv =====
`timescale 1ns / 1ps
`include "serial_to_can_motor_gateway_macros.svh"

module s2cmg_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [s2cmg_pkg::ID_W-1:0]     cfg_wdata,
  input  logic                           chunk_start,
  input  logic [7:0]                     rx_byte,
  input  logic [s2cmg_pkg::ID_W-1:0]     reply_id,
  input  logic [63:0]                    reply_data,
  input  s2cmg_pkg::ctrl_cmd_t           cmd,
  output s2cmg_pkg::dp_stat_t            stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_port,
  output logic [s2cmg_pkg::ID_W-1:0]     out_id,
  output logic [63:0]                    out_data,
  output logic [7:0]                     out_byte,
  output logic                           out_last
);

  localparam int MW = s2cmg_pkg::MOTOR_W;
  localparam int PW = s2cmg_pkg::POS_W;
  localparam int AW = s2cmg_pkg::STORE_AW;
  localparam int JW = s2cmg_pkg::SER_W;
  localparam int IW = s2cmg_pkg::ID_W;

  logic [IW-1:0] base_r;

  // frame collection
  logic [PW-1:0] pos_r, pos_nxt, p;
  logic [7:0]    fb_r [s2cmg_pkg::FRAME_LEN];
  logic [7:0]    fsum_r, fsum_nxt;
  logic          byte_take;

  // broadcast and reply sequencing
  logic [7:0]    code_r;
  logic [MW-1:0] k_r, k_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [7:0]    rsum_r, rsum_nxt;
  logic [7:0]    store_r [s2cmg_pkg::STORE_LEN];
  logic [7:0]    rd_byte;
  logic [7:0]    ser_byte;
  logic          torque;

  // motor reply decode
  logic [IW-1:0] rdiff;
  logic [AW-1:0] widx;
  logic          store_we;

  // output register
  logic          ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= s2cmg_pkg::BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  assign p         = chunk_start ? '0 : pos_r;
  assign byte_take = cmd.byte_we && (p < PW'(s2cmg_pkg::FRAME_LEN));
  assign pos_nxt   = byte_take ? PW'(p + PW'(1)) : pos_r;

  always_comb begin
    fsum_nxt = fsum_r;
    if (byte_take) begin
      if (p == '0) begin
        fsum_nxt = '0;
      end else if (p <= PW'(s2cmg_pkg::SUM_LAST)) begin
        fsum_nxt = fsum_r + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= PW'(s2cmg_pkg::FRAME_LEN);
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign torque = (code_r == s2cmg_pkg::CMD_TORQUE);

  // frame shifts in from the top; torque bytes shift down two per motor sent
  always_ff @(posedge clk) begin
    fsum_r <= fsum_nxt;
    if (byte_take) begin
      fb_r[s2cmg_pkg::FRAME_LEN-1] <= rx_byte;
      for (int i = 0; i < s2cmg_pkg::FRAME_LEN - 1; i++) begin
        fb_r[i] <= fb_r[i+1];
      end
    end else if (cmd.emit_can && torque) begin
      for (int i = 1; i < s2cmg_pkg::SUM_LAST - 1; i++) begin
        fb_r[i] <= fb_r[i+2];
      end
    end
  end

  assign stat.frame_done = (p == PW'(s2cmg_pkg::FRAME_LEN - 1));
  assign stat.query      = (fb_r[1] == s2cmg_pkg::QUERY_MARK) ||
                           (fb_r[s2cmg_pkg::SUM_LAST+1] == s2cmg_pkg::QUERY_MARK);
  assign stat.frame_ok   = (fb_r[0] == s2cmg_pkg::HDR_BYTE) &&
                           (fb_r[s2cmg_pkg::FRAME_LEN-1] == s2cmg_pkg::TRL_BYTE) &&
                           (stat.query ||
                            (fsum_r == fb_r[s2cmg_pkg::SUM_LAST+1]) ||
                            (fb_r[s2cmg_pkg::SUM_LAST+1] == s2cmg_pkg::NO_CHECK));

  // motor reply store
  assign rdiff    = IW'(reply_id - base_r);
  assign widx     = AW'({rdiff[MW-1:0], 1'b0});
  assign store_we = cmd.reply_we &&
                    ((reply_data[7:0] == s2cmg_pkg::CMD_QUERY) ||
                     (reply_data[7:0] == s2cmg_pkg::CMD_TORQUE)) &&
                    (rdiff < IW'(s2cmg_pkg::MOTORS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < s2cmg_pkg::STORE_LEN; i++) begin
        store_r[i] <= '0;
      end
    end else if (store_we) begin
      store_r[widx]                  <= reply_data[23:16];
      store_r[widx + AW'(1)]         <= reply_data[31:24];
      store_r[widx + AW'(16)]        <= reply_data[55:48];
      store_r[widx + AW'(17)]        <= reply_data[63:56];
    end
  end

  // sequencing counters
  assign k_nxt = cmd.cmd_load ? '0 : (cmd.emit_can ? MW'(k_r + MW'(1)) : k_r);
  assign j_nxt = cmd.cmd_load ? '0 : (cmd.emit_ser ? JW'(j_r + JW'(1)) : j_r);

  assign rd_byte = store_r[AW'(j_r - JW'(1))];

  always_comb begin
    if (j_r == '0) begin
      ser_byte = s2cmg_pkg::HDR_BYTE;
    end else if (j_r <= JW'(s2cmg_pkg::STORE_LEN)) begin
      ser_byte = rd_byte;
    end else if (j_r == JW'(s2cmg_pkg::STORE_LEN + 1)) begin
      ser_byte = rsum_r;
    end else begin
      ser_byte = s2cmg_pkg::TRL_BYTE;
    end
  end

  always_comb begin
    rsum_nxt = rsum_r;
    if (cmd.emit_ser) begin
      if (j_r == '0) begin
        rsum_nxt = '0;
      end else if (j_r <= JW'(s2cmg_pkg::STORE_LEN)) begin
        rsum_nxt = rsum_r + rd_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      j_r <= '0;
    end else begin
      k_r <= k_nxt;
      j_r <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsum_r <= rsum_nxt;
    if (cmd.cmd_load) begin
      code_r <= cmd.cmd_code;
    end
  end

  assign stat.k_last   = (k_r == MW'(s2cmg_pkg::MOTORS - 1));
  assign stat.j_last   = (j_r == JW'(s2cmg_pkg::SER_LEN - 1));
  assign stat.out_free = !ov_r || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_can || cmd.emit_ser) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_can) begin
      out_port <= 1'b0;
      out_id   <= IW'(base_r + IW'(k_r));
      out_data <= torque ? {16'h0, fb_r[2], fb_r[1], 24'h0, code_r} : {56'h0, code_r};
      out_byte <= '0;
      out_last <= cmd.out_last;
    end else if (cmd.emit_ser) begin
      out_port <= 1'b1;
      out_id   <= '0;
      out_data <= '0;
      out_byte <= ser_byte;
      out_last <= cmd.out_last;
    end
  end

  assign out_valid = ov_r;

  `S2CMG_ASSERT_IMPL(a_pos_range, 1'b1, pos_r <= PW'(s2cmg_pkg::FRAME_LEN))
  `S2CMG_ASSERT_IMPL(a_ser_last, cmd.emit_ser && stat.j_last, cmd.out_last)
  `S2CMG_ASSERT_NEXT(a_out_hold, ov_r && !out_ready, ov_r)

endmodule

// ===== rtl/core/serial_to_can_motor_gateway.sv =====
`timescale 1ns / 1ps
// serial to can motor gateway: serial bytes build 19-byte command frames (0x5a, eight
// 16-bit torques low byte first, checksum, 0xa5); a good frame sends eight 0xa1 torque
// can frames, or eight 0x9c status queries when byte 1 or byte 17 is 0xff, followed by a
// 35-byte serial reply made from the stored motor replies; can reply words update that
// store, start and stop words broadcast 0x81 and 0x88 to all motors. an input word is
// taken only while the sequencer is idle; the word that completes a frame is followed
// by a check state for the header, trailer and checksum test. results leave one per
// cycle through a single output register as long as out_tready stays high.
module serial_to_can_motor_gateway (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: motor_id_base
  input  logic                       cfg_we,
  input  logic [s2cmg_pkg::ID_W-1:0] cfg_wdata,
  // input words
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [87:0]                in_tdata,   // rx_byte, reply_id, reply_data, zero pad
  input  logic [2:0]                 in_tuser,   // func, chunk_start
  // result words
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [87:0]                out_tdata,  // tx_id, tx_data, tx_byte, zero pad
  output logic                       out_tuser,  // port
  output logic                       out_tlast
);

  s2cmg_pkg::ctrl_cmd_t cmd;
  s2cmg_pkg::dp_stat_t  stat;

  logic [s2cmg_pkg::ID_W-1:0] tx_id;
  logic [63:0]                tx_data;
  logic [7:0]                 tx_byte;

  // sequencer: word intake, frame check, broadcast and reply phases
  s2cmg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser[1:0]),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // frame buffer, reply store, counters and result register
  s2cmg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .chunk_start (in_tuser[2]),
    .rx_byte     (in_tdata[7:0]),
    .reply_id    (in_tdata[18:8]),
    .reply_data  (in_tdata[82:19]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_port    (out_tuser),
    .out_id      (tx_id),
    .out_data    (tx_data),
    .out_byte    (tx_byte),
    .out_last    (out_tlast)
  );

  // pack result fields, lowest first
  assign out_tdata = {5'b0, tx_byte, tx_data, tx_id};

endmodule

// ===== verif/s2cmg_result_checker.sv =====
`timescale 1ns / 1ps

module s2cmg_result_checker
  import s2cmg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [ID_W-1:0] cfg_wdata,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [87:0]     in_tdata,   // rx_byte, reply_id, reply_data, zero pad
  input  logic [2:0]      in_tuser,   // func, chunk_start
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [87:0]     out_tdata,  // tx_id, tx_data, tx_byte, zero pad
  input  logic            out_tuser,  // port
  input  logic            out_tlast,
  output int              fail_count,
  output int              pending,
  output int              checked
);

  typedef struct packed {
    logic            port;
    logic [ID_W-1:0] id;
    logic [63:0]     payload;
    logic [7:0]      ser;
    logic            last;
  } gw_word_t;

  gw_word_t        due_words[$];
  gw_word_t        want;
  gw_word_t        got;
  int              n_before;
  logic [ID_W-1:0] id_base;
  int              frame_fill;
  logic [7:0]      frame[FRAME_LEN];
  logic [7:0]      motor_store[STORE_LEN];

  task automatic push_can(input logic [ID_W-1:0] id, input logic [63:0] payload);
    due_words.push_back('{1'b0, id, payload, 8'h00, 1'b0});
  endtask

  task automatic push_ser(input logic [7:0] b);
    due_words.push_back('{1'b1, '0, 64'd0, b, 1'b0});
  endtask

  task automatic broadcast(input logic [7:0] cmd);
    for (int k = 0; k < MOTORS; k++) push_can(id_base + ID_W'(k), {56'd0, cmd});
  endtask

  // header, the stored reply bytes, their sum, trailer
  task automatic serial_reply();
    logic [7:0] sum;
    sum = '0;
    push_ser(HDR_BYTE);
    for (int i = 0; i < STORE_LEN; i++) begin
      sum += motor_store[i];
      push_ser(motor_store[i]);
    end
    push_ser(sum);
    push_ser(TRL_BYTE);
  endtask

  task automatic predict_frame();
    logic [7:0] sum;
    sum = '0;
    if (frame[0] != HDR_BYTE || frame[FRAME_LEN-1] != TRL_BYTE) return;
    if (frame[1] == QUERY_MARK || frame[17] == QUERY_MARK) begin
      broadcast(CMD_QUERY);
    end else begin
      for (int i = 1; i <= SUM_LAST; i++) sum += frame[i];
      if (sum != frame[17] && frame[17] != NO_CHECK) return;
      for (int k = 0; k < MOTORS; k++) begin
        push_can(id_base + ID_W'(k),
                 {16'h0, frame[2+2*k], frame[1+2*k], 24'h0, CMD_TORQUE});
      end
    end
    serial_reply();
  endtask

  task automatic store_motor_reply(input logic [ID_W-1:0] id, input logic [63:0] payload);
    logic [ID_W-1:0] k;
    k = id - id_base;
    if (payload[7:0] != CMD_QUERY && payload[7:0] != CMD_TORQUE) return;
    if (k >= MOTORS) return;
    motor_store[2*k]    = payload[23:16];
    motor_store[2*k+1]  = payload[31:24];
    motor_store[16+2*k] = payload[55:48];
    motor_store[17+2*k] = payload[63:56];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      id_base    = BASE_RESET;
      frame_fill = FRAME_LEN;
      for (int i = 0; i < FRAME_LEN; i++) frame[i] = '0;
      for (int i = 0; i < STORE_LEN; i++) motor_store[i] = '0;
      due_words.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_we) id_base = cfg_wdata;
      if (in_tvalid && in_tready) begin
        n_before = due_words.size();
        case (in_tuser[1:0])
          FUNC_BYTE: begin
            if (in_tuser[2]) frame_fill = 0;
            if (frame_fill < FRAME_LEN) begin
              frame[frame_fill] = in_tdata[7:0];
              frame_fill++;
              if (frame_fill == FRAME_LEN) predict_frame();
            end
          end
          FUNC_REPLY: store_motor_reply(in_tdata[18:8], in_tdata[82:19]);
          FUNC_START: broadcast(CMD_ON);
          default:    broadcast(CMD_OFF);
        endcase
        // flag the final word of this input
        if (due_words.size() > n_before) begin
          want = due_words.pop_back();
          want.last = 1'b1;
          due_words.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[10:0], out_tdata[74:11], out_tdata[82:75], out_tlast};
        checked++;
        if (due_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word port %0d id %h data %h byte %h last %0d",
                     $realtime, got.port, got.id, got.payload, got.ser, got.last);
        end else begin
          want = due_words.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result word mismatch", $realtime);
              $display("  exp port %0d id %h data %h byte %h last %0d",
                       want.port, want.id, want.payload, want.ser, want.last);
              $display("  got port %0d id %h data %h byte %h last %0d",
                       got.port, got.id, got.payload, got.ser, got.last);
            end
          end
        end
      end
    end
    pending = due_words.size();
  end

endmodule

// ===== verif/tb_serial_to_can_motor_gateway.sv =====
`timescale 1ns / 1ps

module tb_serial_to_can_motor_gateway;
  import s2cmg_pkg::*;

  // far above the slowest legal run
  localparam int CYCLE_LIMIT = 500000;

  // ways of shaping a command frame
  typedef enum int {
    FR_GOOD_SUM, FR_SKIP_SUM, FR_QUERY_B1, FR_QUERY_B17,
    FR_BAD_HDR, FR_BAD_TRL, FR_BAD_SUM, FR_SHORT
  } frame_kind_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [ID_W-1:0] cfg_wdata = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [87:0]     in_tdata  = '0;   // rx_byte, reply_id, reply_data, zero pad
  logic [2:0]      in_tuser  = '0;   // func, chunk_start
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [87:0]     out_tdata;        // tx_id, tx_data, tx_byte, zero pad
  logic            out_tuser;        // port
  logic            out_tlast;

  int              fail_count;
  int              pending;
  int              checked;
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  int              words_sent  = 0;
  int              base_writes = 0;
  int              cycles      = 0;
  logic [ID_W-1:0] cur_base    = BASE_RESET;

  serial_to_can_motor_gateway i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // prediction and comparison live in the checker
  s2cmg_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still due", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure, one draw per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // torque bytes lean toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one input word; held until the handshake completes
  task automatic send_word(input logic [1:0] func, input logic chunk, input logic [7:0] b,
                           input logic [ID_W-1:0] id, input logic [63:0] payload);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, payload, id, b};
    in_tuser  <= {chunk, func};
    // tready is stable between edges, so sample it mid-cycle
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  // unused fields carry random junk
  task automatic send_byte(input logic chunk, input logic [7:0] b);
    send_word(FUNC_BYTE, chunk, b, ID_W'($urandom), rand64());
  endtask

  task automatic send_reply(input logic [ID_W-1:0] id, input logic [7:0] cmd);
    logic [63:0] payload;
    payload = rand64();
    send_word(FUNC_REPLY, 1'($urandom), 8'($urandom), id, {payload[63:8], cmd});
  endtask

  task automatic send_broadcast(input logic [1:0] func);
    send_word(func, 1'($urandom), 8'($urandom), ID_W'($urandom), rand64());
  endtask

  task automatic send_frame(input frame_kind_e kind);
    logic [7:0] fb[FRAME_LEN];
    logic [7:0] sum;
    int         len;
    sum = '0;
    fb[0] = HDR_BYTE;
    fb[FRAME_LEN-1] = TRL_BYTE;
    for (int i = 1; i <= SUM_LAST; i++) fb[i] = pick_byte();
    // keep plain frames from turning into queries by accident
    if (fb[1] == QUERY_MARK) fb[1] = 8'hFE;
    for (int i = 1; i <= SUM_LAST; i++) sum += fb[i];
    fb[17] = sum;
    case (kind)
      FR_SKIP_SUM:  fb[17] = NO_CHECK;
      FR_QUERY_B1:  fb[1] = QUERY_MARK;
      FR_QUERY_B17: fb[17] = QUERY_MARK;
      FR_BAD_HDR:   do fb[0] = 8'($urandom); while (fb[0] == HDR_BYTE);
      FR_BAD_TRL:   do fb[FRAME_LEN-1] = 8'($urandom); while (fb[FRAME_LEN-1] == TRL_BYTE);
      FR_BAD_SUM: begin
        do fb[17] = 8'($urandom);
        while (fb[17] == sum || fb[17] == NO_CHECK || fb[17] == QUERY_MARK);
      end
      default: ;
    endcase
    len = (kind == FR_SHORT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    for (int i = 0; i < len; i++) send_byte(i == 0, fb[i]);
    // bytes past the end of a finished frame must be dropped
    if (kind != FR_SHORT && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
  endtask

  // one motor reply, broadcast or stray serial byte
  task automatic random_item();
    int              r;
    logic [ID_W-1:0] id;
    logic [7:0]      cmd;
    r = $urandom_range(99);
    if (r < 50) begin
      // mostly replies from our motors with a known command byte
      id  = ($urandom_range(9) == 0) ? ID_W'($urandom)
                                     : cur_base + ID_W'($urandom_range(MOTORS - 1));
      cmd = ($urandom_range(7) == 0) ? 8'($urandom)
                                     : ($urandom_range(1) ? CMD_QUERY : CMD_TORQUE);
      send_reply(id, cmd);
    end else if (r < 75) begin
      send_broadcast($urandom_range(1) ? FUNC_START : FUNC_STOP);
    end else begin
      send_byte(1'($urandom), 8'($urandom));
    end
  endtask

  // let every due word drain, plus slack for a frame that gives no output
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_base(input logic [ID_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base  = v;
    base_writes++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset base, sender idle 21, receiver idle 76
    tx_idle_pct = 21;
    rx_idle_pct <= 76;
    // bytes with no frame open
    send_byte(1'b0, 8'h5A);
    send_byte(1'b0, 8'hA5);
    send_broadcast(FUNC_START);
    send_broadcast(FUNC_STOP);
    // store updates: first and last motor, payload extremes
    send_word(FUNC_REPLY, 1'b0, 8'h00, cur_base, {56'hFF_FFFF_FFFF_FFFF, CMD_QUERY});
    send_word(FUNC_REPLY, 1'b1, 8'hFF, cur_base + ID_W'(MOTORS - 1), {56'd0, CMD_TORQUE});
    send_reply(cur_base + ID_W'(3), CMD_TORQUE);
    // replies that must be ignored: unknown command, foreign identifiers
    send_reply(cur_base + ID_W'(2), 8'h00);
    send_reply(cur_base + ID_W'(MOTORS), CMD_QUERY);
    send_reply(cur_base - ID_W'(1), CMD_TORQUE);

    // frame shapes spread over three phases, each with its own base and handshake mix
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct <= 76;
          write_base('0);
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct <= 21;
          write_base('1);   // motor identifiers wrap past the top
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          write_base(ID_W'($urandom));
        end
      endcase
      for (int k = phase; k <= FR_SHORT; k += 3) begin
        send_frame(frame_kind_e'(k));
        random_item();
      end
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    @(negedge clk);
    $display("sent %0d input words over three handshake mixes and %0d base settings",
             words_sent, base_writes + 1);
    $display("checked %0d result words, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
